[rtl/cgap_pkg.sv]
// Shared constants, command/status types and widths for the Carmichael test block.
package cgap_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned DIV_W       = VALUE_WIDTH / 2 + 1;
  localparam int unsigned SQ_W        = 2 * DIV_W;
  localparam int unsigned CNT_W       = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned OUT_DATA_W  = 3 * VALUE_WIDTH;
  localparam int unsigned OUT_USER_W  = 2;

  localparam logic [VALUE_WIDTH-1:0] GAP_RESET = VALUE_WIDTH'(1000);

  typedef enum logic [1:0] {
    SEL_COF_D,
    SEL_NM1_DM1,
    SEL_NM1_COFM1
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     sq_en;
    logic     div_go;
    div_sel_e div_sel;
    logic     take_quot;
    logic     adv_d;
    logic     emit;
    logic     carm;
  } cmd_t;

  typedef struct packed {
    logic below_two;
    logic sq_gt;
    logic cof_is_n;
    logic div_done;
    logic rem_zero;
    logic out_busy;
  } sts_t;

endpackage

[rtl/cgap_div.sv]
// Restoring divider, one quotient bit per cycle.
module cgap_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [cgap_pkg::VALUE_WIDTH-1:0] dividend_i,
  input  logic [cgap_pkg::VALUE_WIDTH-1:0] divisor_i,
  output logic                            done_o,
  output logic [cgap_pkg::VALUE_WIDTH-1:0] quot_o,
  output logic [cgap_pkg::VALUE_WIDTH-1:0] rem_o
);
  import cgap_pkg::*;

  logic                   busy_q, busy_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] quot_q, quot_d;
  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [VALUE_WIDTH-1:0] dvs_q, dvs_d;
  logic [VALUE_WIDTH:0]   shifted;
  logic [VALUE_WIDTH:0]   sub;
  logic                   ge;

  assign shifted = {rem_q, quot_q[VALUE_WIDTH-1]};
  assign sub     = shifted - {1'b0, dvs_q};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign done_o  = busy_q && (cnt_q == '0);
  assign quot_o  = quot_q;
  assign rem_o   = rem_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(VALUE_WIDTH);
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d  = cnt_q - CNT_W'(1);
        rem_d  = ge ? sub[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
        quot_d = {quot_q[VALUE_WIDTH-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

endmodule

[rtl/cgap_ctrl.sv]
// Sequencer for the trial-division test: issues datapath commands, tracks the verdict.
module cgap_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cgap_pkg::sts_t sts_i,
  output cgap_pkg::cmd_t cmd_o
);
  import cgap_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_SQR   = 4'd2;
  localparam logic [3:0] S_CMP   = 4'd3;
  localparam logic [3:0] S_W1    = 4'd4;
  localparam logic [3:0] S_D2    = 4'd5;
  localparam logic [3:0] S_W2    = 4'd6;
  localparam logic [3:0] S_W3    = 4'd7;
  localparam logic [3:0] S_WF    = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  logic [3:0] state_q, state_d;
  logic       carm_q, carm_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    carm_d  = carm_q;
    cmd_o   = '0;
    cmd_o.div_sel = SEL_COF_D;
    cmd_o.carm    = carm_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          carm_d     = 1'b0;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = sts_i.below_two ? S_EMIT : S_SQR;
      end
      S_SQR: begin
        cmd_o.sq_en = 1'b1;
        state_d     = S_CMP;
      end
      S_CMP: begin
        if (!sts_i.sq_gt) begin
          cmd_o.div_go = 1'b1;
          state_d      = S_W1;
        end else if (sts_i.cof_is_n) begin
          // cofactor untouched: the candidate is prime
          state_d = S_EMIT;
        end else begin
          cmd_o.div_go  = 1'b1;
          cmd_o.div_sel = SEL_NM1_COFM1;
          state_d       = S_WF;
        end
      end
      S_W1: begin
        if (sts_i.div_done) begin
          if (sts_i.rem_zero) begin
            cmd_o.take_quot = 1'b1;
            state_d         = S_D2;
          end else begin
            cmd_o.adv_d = 1'b1;
            state_d     = S_SQR;
          end
        end
      end
      S_D2: begin
        cmd_o.div_go = 1'b1;
        state_d      = S_W2;
      end
      S_W2: begin
        if (sts_i.div_done) begin
          if (sts_i.rem_zero) begin
            // square factor
            state_d = S_EMIT;
          end else begin
            cmd_o.div_go  = 1'b1;
            cmd_o.div_sel = SEL_NM1_DM1;
            state_d       = S_W3;
          end
        end
      end
      S_W3: begin
        if (sts_i.div_done) begin
          if (sts_i.rem_zero) begin
            cmd_o.adv_d = 1'b1;
            state_d     = S_SQR;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_WF: begin
        if (sts_i.div_done) begin
          carm_d  = sts_i.rem_zero;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      carm_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      carm_q  <= carm_d;
    end
  end

endmodule

[rtl/cgap_dpath.sv]
// Datapath: candidate, cofactor and divisor registers, divider, gap tracking, output register.
module cgap_dpath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cgap_pkg::cmd_t                   cmd_i,
  output cgap_pkg::sts_t                   sts_o,
  input  logic [cgap_pkg::VALUE_WIDTH-1:0] in_data_i,
  input  logic                             cfg_we_i,
  input  logic [cgap_pkg::VALUE_WIDTH-1:0] cfg_wdata_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [cgap_pkg::OUT_DATA_W-1:0]  out_data_o,
  output logic [cgap_pkg::OUT_USER_W-1:0]  out_user_o
);
  import cgap_pkg::*;

  logic [VALUE_WIDTH-1:0] n_q, nm1_q, cof_q;
  logic [DIV_W-1:0]       d_q;
  logic [SQ_W-1:0]        sq_q;
  logic [VALUE_WIDTH-1:0] last_q, max_gap_q;
  logic                   out_valid_q;
  logic [OUT_DATA_W-1:0]  out_data_q;
  logic [OUT_USER_W-1:0]  out_user_q;

  logic [VALUE_WIDTH-1:0] dividend, divisor, quot, rem;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] gap;
  logic                   close;

  always_comb begin
    case (cmd_i.div_sel)
      SEL_NM1_DM1: begin
        dividend = nm1_q;
        divisor  = VALUE_WIDTH'(d_q - DIV_W'(1));
      end
      SEL_NM1_COFM1: begin
        dividend = nm1_q;
        divisor  = cof_q - VALUE_WIDTH'(1);
      end
      default: begin
        dividend = cof_q;
        divisor  = VALUE_WIDTH'(d_q);
      end
    endcase
  end

  cgap_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  assign gap   = n_q - last_q;
  assign close = cmd_i.carm && (last_q != '0) && (gap <= max_gap_q);

  assign sts_o.below_two = n_q < VALUE_WIDTH'(2);
  assign sts_o.sq_gt     = sq_q > SQ_W'(cof_q);
  assign sts_o.cof_is_n  = cof_q == n_q;
  assign sts_o.div_done  = div_done;
  assign sts_o.rem_zero  = rem == '0;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q   <= in_data_i;
      nm1_q <= in_data_i - VALUE_WIDTH'(1);
      cof_q <= in_data_i;
      d_q   <= DIV_W'(2);
    end else begin
      if (cmd_i.take_quot) begin
        cof_q <= quot;
      end
      if (cmd_i.adv_d) begin
        d_q <= (d_q == DIV_W'(2)) ? DIV_W'(3) : d_q + DIV_W'(2);
      end
    end
    if (cmd_i.sq_en) begin
      sq_q <= SQ_W'(d_q) * SQ_W'(d_q);
    end
    if (cmd_i.emit) begin
      out_data_q <= {gap, last_q, n_q};
      out_user_q <= {close, cmd_i.carm};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '0;
      max_gap_q   <= GAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_gap_q <= cfg_wdata_i;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        if (cmd_i.carm) begin
          last_q <= n_q;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

[rtl/carmichael_test_with_gap_report.sv]
// Top level: Carmichael number test by Korselt's criterion with a close-pair gap report.
//
// Each request on the slave stream carries one candidate n. The block trial-divides n by 2
// and then by 3, 5, 7, ... while the divisor squared is at most the remaining cofactor; a
// divisor that divides must not divide again and d-1 must divide n-1, and the final cofactor
// q must differ from n with q-1 dividing n-1. One result leaves on the master stream per
// candidate. Candidates are tested one at a time; the next is taken once the verdict is in
// the output register, which may still be waiting for the downstream side. All modulo work
// runs through one shared restoring divider at one quotient bit per cycle. Each trial divisor
// that does not divide costs a square, a compare and a division; each one that does costs two
// more divisions. The last Carmichael number found is kept; a result flags a close pair when
// the candidate is Carmichael, a previous one exists, and the gap (candidate minus previous,
// mod 2^32) is at most max_gap (reset 1000). Write max_gap through cfg_we_i only while the
// block is idle.
module carmichael_test_with_gap_report (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // slave stream: [31:0] candidate
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [cgap_pkg::VALUE_WIDTH-1:0] s_axis_tdata,
  // master stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [31:0] tested_value, [63:32] previous_found, [95:64] gap_size
  output logic [cgap_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // [0] is_carmichael_flag, [1] close_pair
  output logic [cgap_pkg::OUT_USER_W-1:0]  m_axis_tuser,
  // max_gap register write
  input  logic                             cfg_we_i,
  input  logic [cgap_pkg::VALUE_WIDTH-1:0] cfg_wdata_i
);
  import cgap_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequence the trial division
  cgap_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // hold operands, divide, track the previous hit and register the result
  cgap_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

[rtl/cgap_checker.sv]
// Port-level checks for the Carmichael test block, bound to the top level.
module cgap_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [cgap_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [cgap_pkg::OUT_USER_W-1:0] m_axis_tuser
);
  import cgap_pkg::*;

  logic [VALUE_WIDTH-1:0] tested, prev, gap;

  assign tested = m_axis_tdata[VALUE_WIDTH-1:0];
  assign prev   = m_axis_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
  assign gap    = m_axis_tdata[3*VALUE_WIDTH-1:2*VALUE_WIDTH];

  // one request at a time: ready drops after an accept
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while busy");

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // close pair only for a Carmichael hit with a previous one
  a_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0] && (prev != '0))
    else $error("close pair without Carmichael hit or previous");

  // gap is candidate minus previous
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> gap == tested - prev)
    else $error("gap mismatch");

  // Carmichael numbers are odd
  a_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> tested[0])
    else $error("even value flagged Carmichael");

endmodule

bind carmichael_test_with_gap_report cgap_checker u_cgap_checker (.*);
